@@ rtl/core/mter_pkg.sv @@
// shared types and constants for the manchester edge timing receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mter_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // window thresholds for the reset bit period of 250 ticks
  localparam logic [15:0] LO_RST  = 16'd83;
  localparam logic [15:0] MID_RST = 16'd166;
  localparam logic [16:0] HI_RST  = 17'd333;

  // ceil(2^19 / 3), exact floor(x / 3) for x below 2^18
  localparam logic [17:0] RECIP3 = 18'd174763;

  localparam logic [4:0] FIRST_BYTE_COUNT = 5'd9;
  localparam logic [4:0] FRAME_COUNT      = 5'd17;

  typedef enum logic [1:0] {
    REQ_EDGE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_ARM     = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    WIN_HALF = 2'd0,
    WIN_FULL = 2'd1,
    WIN_BAD  = 2'd2
  } win_t;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_LONG    = 3'd2,
    ST_BAD     = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] interval;
    logic        line_active;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] word;
    logic        running;
  } out_item_t;

  typedef struct packed {
    req_t req;
    win_t win;
    logic line_active;
  } cls_t;

endpackage

`default_nettype wire

@@ rtl/core/mter_front.sv @@
// front end: holds window thresholds and classifies each request
// depends on mter_pkg
`timescale 1ns / 1ps
`default_nettype none

module mter_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mter_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output mter_pkg::cls_t         q_wdata
);

  logic [15:0] lo_r, lo_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [16:0] hi_r, hi_nxt;
  logic [17:0] x_lo, x_mid, x_hi;
  logic [35:0] p_lo, p_mid, p_hi;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  assign x_lo  = {2'b00, cfg_data};
  assign x_mid = {1'b0, cfg_data, 1'b0};
  assign x_hi  = {cfg_data, 2'b00};

  assign p_lo  = x_lo * mter_pkg::RECIP3;
  assign p_mid = x_mid * mter_pkg::RECIP3;
  assign p_hi  = x_hi * mter_pkg::RECIP3;

  assign lo_nxt  = cfg_we ? p_lo[34:19]  : lo_r;
  assign mid_nxt = cfg_we ? p_mid[34:19] : mid_r;
  assign hi_nxt  = cfg_we ? p_hi[35:19]  : hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= mter_pkg::LO_RST;
      mid_r <= mter_pkg::MID_RST;
      hi_r  <= mter_pkg::HI_RST;
    end else begin
      lo_r  <= lo_nxt;
      mid_r <= mid_nxt;
      hi_r  <= hi_nxt;
    end
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready;

  always_comb begin
    q_wdata.req         = mter_pkg::req_t'(in_data.req_type);
    q_wdata.line_active = in_data.line_active;
    if ((lo_r < in_data.interval) && (in_data.interval < mid_r)) begin
      q_wdata.win = mter_pkg::WIN_HALF;
    end else if ((mid_r < in_data.interval) && ({1'b0, in_data.interval} < hi_r)) begin
      q_wdata.win = mter_pkg::WIN_FULL;
    end else begin
      q_wdata.win = mter_pkg::WIN_BAD;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mter_queue.sv @@
// short queue of classified requests between front and back
// depends on mter_pkg
`timescale 1ns / 1ps
`default_nettype none

module mter_queue #(
  parameter int unsigned DEPTH = mter_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mter_pkg::cls_t wdata,
  output logic                full,
  input  wire logic           pop,
  output mter_pkg::cls_t      rdata,
  output logic                empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mter_pkg::cls_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mter_back.sv @@
// back end: manchester decode state and registered result
// depends on mter_pkg
`timescale 1ns / 1ps
`default_nettype none

module mter_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire mter_pkg::cls_t     q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mter_pkg::out_item_t     out_data
);

  logic [4:0]          bit_count_r, bit_count_nxt;
  logic                expect_long_r, expect_long_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [7:0]          high_r, high_nxt;
  logic                stopped_r, stopped_nxt;
  mter_pkg::status_t   status_r, status_nxt;
  logic [15:0]         word_r, word_nxt;
  logic                out_valid_r, out_valid_nxt;
  mter_pkg::out_item_t out_data_r, out_data_nxt;

  logic                halt;
  logic                take;
  mter_pkg::status_t   hcode;
  logic [4:0]          cnt_tb;
  logic [7:0]          shift_tb;

  assign q_pop     = ~q_empty & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    halt            = 1'b0;
    take            = 1'b0;
    hcode           = mter_pkg::ST_RUN;
    cnt_tb          = bit_count_r + 5'd1;
    shift_tb        = {shift_r[6:0], ~q_rdata.line_active};
    bit_count_nxt   = bit_count_r;
    expect_long_nxt = expect_long_r;
    shift_nxt       = shift_r;
    high_nxt        = high_r;
    stopped_nxt     = stopped_r;
    status_nxt      = status_r;
    word_nxt        = word_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_data_nxt    = out_data_r;
    if (q_pop) begin
      case (q_rdata.req)
        mter_pkg::REQ_ARM: begin
          bit_count_nxt = '0;
          status_nxt    = mter_pkg::ST_RUN;
          stopped_nxt   = 1'b0;
        end
        mter_pkg::REQ_TIMEOUT: begin
          if (!stopped_r) begin
            halt  = 1'b1;
            hcode = mter_pkg::ST_TIMEOUT;
          end
        end
        mter_pkg::REQ_EDGE: begin
          if (!stopped_r) begin
            if (bit_count_r == '0) begin
              // start bit
              if (q_rdata.line_active) begin
                expect_long_nxt = 1'b0;
                bit_count_nxt   = 5'd1;
              end
            end else begin
              case (q_rdata.win)
                mter_pkg::WIN_HALF: begin
                  if (expect_long_r) begin
                    expect_long_nxt = 1'b0;
                  end else begin
                    expect_long_nxt = 1'b1;
                    take            = 1'b1;
                  end
                end
                mter_pkg::WIN_FULL: begin
                  if (expect_long_r) begin
                    take = 1'b1;
                  end else begin
                    halt  = 1'b1;
                    hcode = mter_pkg::ST_LONG;
                  end
                end
                default: begin
                  halt  = 1'b1;
                  hcode = mter_pkg::ST_BAD;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase

      if (take) begin
        shift_nxt     = shift_tb;
        bit_count_nxt = cnt_tb;
        if (cnt_tb == mter_pkg::FIRST_BYTE_COUNT) begin
          high_nxt = shift_tb;
        end else if (cnt_tb == mter_pkg::FRAME_COUNT) begin
          halt  = 1'b1;
          hcode = mter_pkg::ST_DONE;
        end
      end

      if (halt) begin
        stopped_nxt = 1'b1;
        word_nxt    = {high_nxt, shift_nxt};
        status_nxt  = hcode;
      end

      out_valid_nxt        = 1'b1;
      out_data_nxt.status  = status_nxt;
      out_data_nxt.word    = word_nxt;
      out_data_nxt.running = ~stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r   <= '0;
      expect_long_r <= 1'b0;
      shift_r       <= '0;
      high_r        <= '0;
      stopped_r     <= 1'b1;
      status_r      <= mter_pkg::ST_RUN;
      word_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bit_count_r   <= bit_count_nxt;
      expect_long_r <= expect_long_nxt;
      shift_r       <= shift_nxt;
      high_r        <= high_nxt;
      stopped_r     <= stopped_nxt;
      status_r      <= status_nxt;
      word_r        <= word_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/manchester_edge_timing_receiver_top.sv @@
// path: an accepted request is written into the queue, then decoded into the output register when popped
// throughput: one request per cycle while the output is not stalled, one result per request
// front compares against registered window thresholds, back updates decode state
// a two-entry queue and the output register decouple the two sides
// reset: bit period 250 ticks, receiver stopped until an arm request, no result pending
`timescale 1ns / 1ps
`default_nettype none

module manchester_edge_timing_receiver_top #(
  parameter int unsigned QUEUE_DEPTH = mter_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mter_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mter_pkg::out_item_t      out_data
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  mter_pkg::cls_t q_wdata;
  mter_pkg::cls_t q_rdata;

  mter_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mter_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mter_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ bench/manchester_edge_timing_receiver_top_tb.sv @@
// self-checking bench for manchester_edge_timing_receiver_top
// depends on mter_pkg and the top level; a local decoder model predicts each result
`timescale 1ns / 1ps

module manchester_edge_timing_receiver_top_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  mter_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mter_pkg::out_item_t out_data;

  manchester_edge_timing_receiver_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  mter_pkg::in_item_t edge_requests[$];
  mter_pkg::out_item_t predicted_reports[$];
  mter_pkg::out_item_t due_report;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned queued_count = 0;
  int unsigned idle_mode = 0;
  int unsigned stall_trigger = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;

  // decoder model state
  int unsigned period_ticks;
  logic [4:0] bits_taken;
  logic waiting_long;
  logic [7:0] shift_reg;
  logic [7:0] first_byte;
  logic halted;
  mter_pkg::status_t held_status;
  logic [15:0] held_word;

  function automatic void reset_decoder();
    period_ticks = 250;
    bits_taken = '0;
    waiting_long = 1'b0;
    shift_reg = '0;
    first_byte = '0;
    halted = 1'b1;
    held_status = mter_pkg::ST_RUN;
    held_word = '0;
  endfunction

  function automatic void stop_frame(mter_pkg::status_t code);
    halted = 1'b1;
    held_word = {first_byte, shift_reg};
    held_status = code;
  endfunction

  function automatic void shift_bit(logic active);
    shift_reg = {shift_reg[6:0], ~active};
    bits_taken = bits_taken + 5'd1;
    if (bits_taken == mter_pkg::FIRST_BYTE_COUNT) begin
      first_byte = shift_reg;
    end else if (bits_taken == mter_pkg::FRAME_COUNT) begin
      stop_frame(mter_pkg::ST_DONE);
    end
  endfunction

  function automatic void take_edge(logic [15:0] iv, logic active);
    int unsigned lo;
    int unsigned mid;
    int unsigned hi;
    lo = period_ticks / 3;
    mid = (period_ticks * 2) / 3;
    hi = (period_ticks * 4) / 3;
    if (bits_taken == 5'd0) begin
      if (active) begin
        waiting_long = 1'b0;
        bits_taken = 5'd1;
      end
    end else if (iv > lo && iv < mid) begin
      if (waiting_long) begin
        waiting_long = 1'b0;
      end else begin
        waiting_long = 1'b1;
        shift_bit(active);
      end
    end else if (iv > mid && iv < hi) begin
      if (waiting_long) begin
        shift_bit(active);
      end else begin
        stop_frame(mter_pkg::ST_LONG);
      end
    end else begin
      stop_frame(mter_pkg::ST_BAD);
    end
  endfunction

  function automatic mter_pkg::out_item_t decode_step(mter_pkg::in_item_t r);
    mter_pkg::out_item_t res;
    case (mter_pkg::req_t'(r.req_type))
      mter_pkg::REQ_ARM: begin
        bits_taken = '0;
        held_status = mter_pkg::ST_RUN;
        halted = 1'b0;
      end
      mter_pkg::REQ_EDGE: begin
        if (!halted) take_edge(r.interval, r.line_active);
      end
      mter_pkg::REQ_TIMEOUT: begin
        if (!halted) stop_frame(mter_pkg::ST_TIMEOUT);
      end
      default: ;
    endcase
    res.status = held_status;
    res.word = held_word;
    res.running = ~halted;
    return res;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_mode)
      0: return 14;
      1: return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (idle_mode)
      0: return 51;
      1: return 14;
      default: return 0;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_reports.push_back(decode_step(in_data));
      end
      if (!in_valid || in_ready) begin
        if (edge_requests.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_valid <= 1'b1;
          in_data <= edge_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          $error("unexpected result: status %0d word %h running %0d",
                 out_data.status, out_data.word, out_data.running);
          mismatches++;
        end else begin
          due_report = predicted_reports.pop_front();
          if (out_data.status !== due_report.status) begin
            $error("status: expected %0d, got %0d", due_report.status, out_data.status);
            mismatches++;
          end
          if (out_data.word !== due_report.word) begin
            $error("word: expected %h, got %h", due_report.word, out_data.word);
            mismatches++;
          end
          if (out_data.running !== due_report.running) begin
            $error("running: expected %0d, got %0d", due_report.running, out_data.running);
            mismatches++;
          end
        end
      end
      if (stall_trigger != stall_seen) begin
        stall_seen = stall_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_req(mter_pkg::req_t kind, logic [15:0] iv, logic active);
    mter_pkg::in_item_t r;
    r.req_type = kind;
    r.interval = iv;
    r.line_active = active;
    edge_requests.push_back(r);
    queued_count++;
  endtask

  function automatic logic [15:0] half_iv();
    int unsigned lo;
    int unsigned mid;
    lo = period_ticks / 3;
    mid = (period_ticks * 2) / 3;
    if (mid > lo + 1) return 16'($urandom_range(mid - 1, lo + 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] full_iv();
    int unsigned mid;
    int unsigned top;
    mid = (period_ticks * 2) / 3;
    top = (period_ticks * 4) / 3 - 1;
    if (top > 65535) top = 65535;
    if (top > mid) return 16'($urandom_range(top, mid + 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_frame(int unsigned nbits, logic complete);
    logic [15:0] data;
    logic gl;
    logic prev;
    logic b;
    int unsigned i;
    int unsigned edge_pick;
    data = 16'($urandom);
    gl = 1'b0;
    prev = 1'b0;
    push_req(mter_pkg::REQ_ARM, 16'($urandom), 1'($urandom));
    if ($urandom_range(3) == 0) push_req(mter_pkg::REQ_EDGE, 16'($urandom), 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'($urandom), 1'b1);
    for (i = 0; i < nbits; i++) begin
      b = data[15 - i];
      if (gl && b != prev) begin
        push_req(mter_pkg::REQ_EDGE, full_iv(), ~b);
      end else begin
        if (gl) push_req(mter_pkg::REQ_EDGE, half_iv(), b);
        push_req(mter_pkg::REQ_EDGE, half_iv(), ~b);
      end
      gl = 1'b1;
      prev = b;
    end
    if (!complete) begin
      case ($urandom_range(4))
        0: push_req(mter_pkg::REQ_TIMEOUT, 16'($urandom), 1'($urandom));
        1: push_req(mter_pkg::REQ_EDGE, 16'($urandom), 1'($urandom));
        2: begin
          edge_pick = $urandom_range(2);
          if (edge_pick == 0) begin
            push_req(mter_pkg::REQ_EDGE, 16'(period_ticks / 3), 1'($urandom));
          end else if (edge_pick == 1) begin
            push_req(mter_pkg::REQ_EDGE, 16'((period_ticks * 2) / 3), 1'($urandom));
          end else begin
            push_req(mter_pkg::REQ_EDGE, 16'((period_ticks * 4) / 3), 1'($urandom));
          end
        end
        3: begin
          if (gl) push_req(mter_pkg::REQ_EDGE, half_iv(), prev);
          push_req(mter_pkg::REQ_EDGE, full_iv(), 1'($urandom));
        end
        default: push_req(mter_pkg::REQ_EDGE, 16'd0, 1'($urandom));
      endcase
    end
    if ($urandom_range(3) == 0) begin
      push_req(mter_pkg::req_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_requests(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_frame(16, 1'b1);
      end else if (pick < 80) begin
        send_frame($urandom_range(0, 15), 1'b0);
      end else begin
        push_req(mter_pkg::req_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic directed_requests();
    int unsigned lo;
    int unsigned mid;
    int unsigned hi;
    lo = period_ticks / 3;
    mid = (period_ticks * 2) / 3;
    hi = (period_ticks * 4) / 3;
    // stopped after reset
    push_req(mter_pkg::REQ_EDGE, 16'd100, 1'b1);
    push_req(mter_pkg::REQ_TIMEOUT, 16'hFFFF, 1'b0);
    push_req(mter_pkg::REQ_NONE, 16'hFFFF, 1'b1);
    push_req(mter_pkg::REQ_ARM, 16'd0, 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'd0, 1'b0);
    push_req(mter_pkg::REQ_NONE, 16'h5555, 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'hFFFF, 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(lo + 1), 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'(hi - 1), 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(mid - 1), 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'(mid + 1), 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'hAAAA, 1'b1);
    push_req(mter_pkg::REQ_ARM, 16'hFFFF, 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'd0, 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(mid), 1'b0);
    push_req(mter_pkg::REQ_ARM, 16'd0, 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'd1, 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(lo), 1'b1);
    push_req(mter_pkg::REQ_ARM, 16'd0, 1'b0);
    push_req(mter_pkg::REQ_EDGE, 16'd1, 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(lo + 1), 1'b1);
    push_req(mter_pkg::REQ_EDGE, 16'(hi), 1'b0);
    push_req(mter_pkg::REQ_ARM, 16'd0, 1'b0);
    push_req(mter_pkg::REQ_TIMEOUT, 16'd0, 1'b1);
    push_req(mter_pkg::REQ_ARM, 16'd0, 1'b0);
  endtask

  task automatic wait_drained();
    while (edge_requests.size() != 0 || in_valid || predicted_reports.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_period(logic [15:0] value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_ticks = value;
    @(negedge clk);
  endtask

  function automatic logic [15:0] phase_period(int unsigned ph);
    case (ph)
      0: return 16'd6;
      1: return 16'd65535;
      2: return 16'd7;
      3: return 16'($urandom_range(6, 40));
      4: return 16'd250;
      5: return 16'($urandom_range(6, 65535));
      6: return 16'd8;
      7: return 16'($urandom_range(41, 2000));
      default: return 16'($urandom_range(6, 65535));
    endcase
  endfunction

  initial begin
    int unsigned ph;
    reset_decoder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_mode = 0;
    directed_requests();
    for (ph = 0; ph < 9; ph++) begin
      write_period(phase_period(ph));
      idle_mode = ph / 3;
      if (ph == 1) begin
        // receiver holds off while requests keep coming
        stall_trigger++;
        random_requests(75);
      end else if (ph == 4) begin
        random_requests(37);
        wait_drained();
        random_requests(38);
      end else begin
        random_requests(75);
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
